>>> hw/rtl/rmcr_pkg.sv
// rmcr_pkg: shared types, constants and codes of the column ray caster
// no dependencies; imported by every rmcr module and the top level

package rmcr_pkg;

   // default module parameters
   localparam int DEF_SCREEN_WIDTH  = 120;
   localparam int DEF_SCREEN_HEIGHT = 40;
   localparam int DEF_MAX_STEPS     = 1000;
   localparam int DEF_MAP_SIZE      = 16;

   // fixed field widths
   localparam int COLUMN_W = 7;
   localparam int POS_W    = 16;
   localparam int MAP_W    = 64;
   localparam int MAG_W    = 19;   // step magnitude, q24
   localparam int RAY_W    = 30;   // signed q24 ray position
   localparam int DIST_W   = 17;
   localparam int ROOT_W   = 19;
   localparam int CSR_IDX_W = 3;

   // decoupling queue
   localparam int QUEUE_DEPTH = 2;

   // sine polynomial and march constants
   localparam logic [15:0] SIN_C1   = 16'd21167;
   localparam logic [15:0] SIN_C2   = 16'd2611;
   localparam logic [15:0] SIN_C3   = 16'd51472;
   localparam logic [15:0] SIN_ONE  = 16'd32768;
   localparam logic [15:0] QUARTER  = 16'd16384;
   localparam logic [15:0] HALF_FOV = 16'd8192;
   localparam logic [19:0] STEP_Q24 = 20'd419430;
   localparam logic [24:0] EDGE_Q24 = 25'd838861;
   localparam int          FULL_LIMIT = 119;

   // distance bands, q12
   localparam logic [ROOT_W-1:0] BAND_1 = ROOT_W'(3 * 4096);
   localparam logic [ROOT_W-1:0] BAND_2 = ROOT_W'(6 * 4096);
   localparam logic [ROOT_W-1:0] BAND_3 = ROOT_W'(12 * 4096);
   localparam logic [ROOT_W-1:0] BAND_4 = ROOT_W'(16 * 4096);

   // shade codes
   localparam logic [2:0] SHADE_BLANK  = 3'd0;
   localparam logic [2:0] SHADE_FULL   = 3'd1;
   localparam logic [2:0] SHADE_DARK   = 3'd2;
   localparam logic [2:0] SHADE_MEDIUM = 3'd3;
   localparam logic [2:0] SHADE_LIGHT  = 3'd4;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLAYER_X = 3'd0,
      CSR_PLAYER_Y = 3'd1,
      CSR_VIEW     = 3'd2,
      CSR_MAP_0    = 3'd3,
      CSR_MAP_1    = 3'd4,
      CSR_MAP_2    = 3'd5,
      CSR_MAP_3    = 3'd6
   } rmcr_csr_type;

   // front sequencer operations
   typedef enum logic [2:0] {
      OP_SETUP, OP_SQ, OP_POLY_A, OP_POLY_B, OP_SINE, OP_STEP
   } rmcr_op_type;

   typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} rmcr_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_MARCH, B_SQX, B_SQY, B_ROOT, B_PREP, B_DIV, B_OUT
   } rmcr_back_state_type;

   // one classified ray, front to back
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic                sx_neg;
      logic [MAG_W-1:0]    sx_mag;
      logic                sy_neg;
      logic [MAG_W-1:0]    sy_mag;
   } rmcr_ray_type;

   // queue handshake toward the back
   typedef struct packed {
      logic valid;
      logic full;
   } rmcr_qstat_type;

endpackage

>>> hw/rtl/rmcr_queue.sv
// rmcr_queue: short fifo of rays between front and back
// depends on rmcr_pkg

module rmcr_queue import rmcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rmcr_ray_type push_ray,
   input  logic         pop,
   output rmcr_ray_type head_ray,
   output rmcr_qstat_type stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rmcr_ray_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_ray;
      end
   end

   assign head_ray   = entry_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

>>> hw/rtl/rmcr_front.sv
// rmcr_front: accepts a column, forms the ray angle and its step vector
// depends on rmcr_pkg; feeds rmcr_queue

module rmcr_front import rmcr_pkg::*; #(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COLUMN_W-1:0] req_column,
   input  logic [POS_W-1:0]    view_angle,
   input  logic                q_full,
   output logic                q_push,
   output rmcr_ray_type        q_ray
);

   localparam int NUM_COLS = 2 ** COLUMN_W;

   rmcr_front_state_type state_ff, state_in;
   rmcr_op_type          op_ff;
   logic                 phase_ff;

   logic [COLUMN_W-1:0] column_ff;
   logic [15:0]         ang_ff;
   logic [15:0]         u_ff, t2_ff, a_ff, b_ff, s_ff;
   logic                neg_ff;
   logic                cos_neg_ff;
   logic [MAG_W-1:0]    cos_mag_ff;
   logic                sin_neg_ff;
   logic [MAG_W-1:0]    sin_mag_ff;

   logic [15:0] ofs_tab [NUM_COLS];
   logic [15:0] pa;
   logic [14:0] t;
   logic [15:0] u;
   logic [19:0] mul_a;
   logic [15:0] mul_b;
   logic [35:0] prod;
   logic [20:0] prod_sh;

   // column to angle offset table, worked out at elaboration
   for (genvar g = 0; g < NUM_COLS; g++) begin : g_ofs
      localparam int OFS = (g * 16384) / SCREEN_WIDTH;
      assign ofs_tab[g] = 16'(OFS);
   end

   // quadrant fold of the current angle, cosine first
   assign pa = phase_ff ? ang_ff : ang_ff + QUARTER;
   assign t  = {pa[13:0], 1'b0};
   assign u  = pa[14] ? SIN_ONE - {1'b0, t} : {1'b0, t};

   // one shared multiplier
   always_comb begin
      unique case (op_ff)
         OP_SETUP: begin
            mul_a = '0;
            mul_b = '0;
         end
         OP_SQ: begin
            mul_a = 20'(u_ff);
            mul_b = u_ff;
         end
         OP_POLY_A: begin
            mul_a = 20'(SIN_C2);
            mul_b = t2_ff;
         end
         OP_POLY_B: begin
            mul_a = 20'(a_ff);
            mul_b = t2_ff;
         end
         OP_SINE: begin
            mul_a = 20'(b_ff);
            mul_b = u_ff;
         end
         OP_STEP: begin
            mul_a = STEP_Q24;
            mul_b = s_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = 36'(mul_a) * 36'(mul_b);
   assign prod_sh = prod[35:15];

   // sequencer state
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = F_CALC;
         end
         F_CALC: begin
            if (op_ff == OP_STEP && phase_ff) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         op_ff    <= OP_SETUP;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_IDLE) begin
            op_ff    <= OP_SETUP;
            phase_ff <= 1'b0;
         end else if (state_ff == F_CALC) begin
            if (op_ff == OP_STEP) begin
               op_ff    <= OP_SETUP;
               phase_ff <= 1'b1;
            end else begin
               op_ff <= rmcr_op_type'(3'(op_ff + 3'd1));
            end
         end
      end
   end

   // polynomial datapath
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         column_ff <= req_column;
         ang_ff    <= view_angle - HALF_FOV + ofs_tab[req_column];
      end
      if (state_ff == F_CALC) begin
         unique case (op_ff)
            OP_SETUP: begin
               u_ff   <= u;
               neg_ff <= pa[15];
            end
            OP_SQ:     t2_ff <= prod_sh[15:0];
            OP_POLY_A: a_ff  <= SIN_C1 - prod_sh[15:0];
            OP_POLY_B: b_ff  <= SIN_C3 - prod_sh[15:0];
            OP_SINE:   s_ff  <= (prod_sh > 21'(SIN_ONE)) ? SIN_ONE : prod_sh[15:0];
            OP_STEP: begin
               if (phase_ff) begin
                  sin_neg_ff <= neg_ff;
                  sin_mag_ff <= prod_sh[MAG_W-1:0];
               end else begin
                  cos_neg_ff <= neg_ff;
                  cos_mag_ff <= prod_sh[MAG_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign q_ray.column = column_ff;
   assign q_ray.sx_neg = cos_neg_ff;
   assign q_ray.sx_mag = cos_mag_ff;
   assign q_ray.sy_neg = sin_neg_ff;
   assign q_ray.sy_mag = sin_mag_ff;

endmodule

>>> hw/rtl/rmcr_back.sv
// rmcr_back: marches one ray, takes root and divide, classifies, holds the result
// depends on rmcr_pkg; fed from rmcr_queue

module rmcr_back import rmcr_pkg::*; #(
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int MAX_STEPS     = DEF_MAX_STEPS,
   parameter int MAP_SIZE      = DEF_MAP_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  rmcr_qstat_type      q_stat,
   input  rmcr_ray_type        q_ray,
   output logic                q_pop,
   input  logic [POS_W-1:0]    player_x,
   input  logic [POS_W-1:0]    player_y,
   input  logic [4*MAP_W-1:0]  map_bits,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COLUMN_W-1:0] rsp_column_out,
   output logic [5:0]          rsp_wall_top,
   output logic [5:0]          rsp_wall_bottom,
   output logic [2:0]          rsp_shade,
   output logic                rsp_full_column,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [POS_W-1:0]    rsp_hit_x,
   output logic [POS_W-1:0]    rsp_hit_y,
   output logic                rsp_wall_found
);

   localparam int NUM_W  = $clog2(SCREEN_HEIGHT + 1) + 12;
   localparam int SZ_W   = NUM_W + 3;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int DIVC_W = $clog2(NUM_W + 1);
   localparam int CNT_W  = (STEP_W > DIVC_W) ? STEP_W : DIVC_W;
   localparam int SQ_W   = 37;
   localparam logic [NUM_W-1:0] NUM_INIT = NUM_W'(SCREEN_HEIGHT) << 12;
   localparam logic [SZ_W-1:0]  SZ_H     = SZ_W'(SCREEN_HEIGHT);

   rmcr_back_state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;

   rmcr_ray_type        ray_ff;
   logic signed [RAY_W-1:0] rx_ff, ry_ff;
   logic                found_ff;
   logic [SQ_W-1:0]     sum_ff, v_ff, r_ff, bit_ff;
   logic [ROOT_W-1:0]   d_ff;
   logic [ROOT_W-1:0]   rem_ff;
   logic [NUM_W-1:0]    num_ff, quo_ff;

   logic [COLUMN_W-1:0] column_out_ff;
   logic [5:0]          top_ff, bottom_ff;
   logic [2:0]          shade_ff;
   logic                full_ff, found_out_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [POS_W-1:0]    hit_x_ff, hit_y_ff;

   logic signed [RAY_W-1:0] x0, y0, sx, sy, nrx, nry;
   logic                wall;
   logic signed [RAY_W:0] ddx, ddy, adx, ady;
   logic [17:0]         ax, ay, mul_op;
   logic [35:0]         sq;
   logic [SQ_W:0]       root_trial;
   logic [ROOT_W:0]     div_trial;
   logic                div_ge;
   logic                march_end;
   logic                load_out;

   logic [SZ_W-1:0]     size;
   logic                full;
   logic [SZ_W-1:0]     top_val, bot_val;
   logic [24:0]         gx, gy;
   logic                away;
   logic [2:0]          shade;

   // start point and signed step vector
   assign x0 = $signed({2'b00, player_x, 12'd0});
   assign y0 = $signed({2'b00, player_y, 12'd0});
   assign sx = ray_ff.sx_neg ? -$signed({11'd0, ray_ff.sx_mag})
                             :  $signed({11'd0, ray_ff.sx_mag});
   assign sy = ray_ff.sy_neg ? -$signed({11'd0, ray_ff.sy_mag})
                             :  $signed({11'd0, ray_ff.sy_mag});
   assign nrx = rx_ff + sx;
   assign nry = ry_ff + sy;

   // wall lookup, anything off the map is a wall
   always_comb begin
      if (nrx[RAY_W-1] || nry[RAY_W-1]) begin
         wall = 1'b1;
      end else if (nrx[28:24] >= 5'(MAP_SIZE) || nry[28:24] >= 5'(MAP_SIZE)) begin
         wall = 1'b1;
      end else begin
         wall = map_bits[{nry[27:24], nrx[27:24]}];
      end
   end

   assign march_end = wall || (cnt_ff == CNT_W'(MAX_STEPS - 1));

   // distance terms, q12 magnitudes
   assign ddx = (RAY_W+1)'(rx_ff) - (RAY_W+1)'(x0);
   assign ddy = (RAY_W+1)'(ry_ff) - (RAY_W+1)'(y0);
   assign adx = ddx[RAY_W] ? -ddx : ddx;
   assign ady = ddy[RAY_W] ? -ddy : ddy;
   assign ax  = adx[29:12];
   assign ay  = ady[29:12];
   assign mul_op = (state_ff == B_SQX) ? ax : ay;
   assign sq     = 36'(mul_op) * 36'(mul_op);

   // root digit and divide bit
   assign root_trial = (SQ_W+1)'(r_ff) + (SQ_W+1)'(bit_ff);
   assign div_trial  = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge     = (div_trial >= {1'b0, d_ff});

   // size and row span
   always_comb begin
      size = SZ_W'(quo_ff) + (SZ_W'(quo_ff) << 2);
      size = size >> 2;
      full = (d_ff == '0) || (size > SZ_W'(FULL_LIMIT));
      top_val = (size >= SZ_H) ? '0 : ((SZ_H - size) >> 1);
      bot_val = (SZ_H + size) >> 1;
      if (bot_val > SZ_H) bot_val = SZ_H;
      if (full) begin
         top_val = '0;
         bot_val = SZ_H;
      end
   end

   // grid corner test and distance bands
   assign gx   = 25'h100_0000 - {1'b0, rx_ff[23:0]};
   assign gy   = 25'h100_0000 - {1'b0, ry_ff[23:0]};
   assign away = ({1'b0, rx_ff[23:0]} > EDGE_Q24 && gx > EDGE_Q24)
              || ({1'b0, ry_ff[23:0]} > EDGE_Q24 && gy > EDGE_Q24);

   always_comb begin
      if (full) begin
         shade = SHADE_FULL;
      end else if (!away) begin
         shade = SHADE_BLANK;
      end else if (d_ff < BAND_1) begin
         shade = SHADE_FULL;
      end else if (d_ff < BAND_2) begin
         shade = SHADE_DARK;
      end else if (d_ff < BAND_3) begin
         shade = SHADE_MEDIUM;
      end else if (d_ff < BAND_4) begin
         shade = SHADE_LIGHT;
      end else begin
         shade = SHADE_BLANK;
      end
   end

   assign load_out = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_stat.valid) begin
               q_pop    = 1'b1;
               state_in = B_MARCH;
            end
         end
         B_MARCH: if (march_end) state_in = B_SQX;
         B_SQX:   state_in = B_SQY;
         B_SQY:   state_in = B_ROOT;
         B_ROOT:  if (bit_ff[0]) state_in = B_PREP;
         B_PREP:  state_in = (r_ff == '0) ? B_OUT : B_DIV;
         B_DIV:   if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = B_OUT;
         B_OUT:   if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_MARCH || state_ff == B_DIV) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ray, root and divide datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            ray_ff   <= q_ray;
            rx_ff    <= x0;
            ry_ff    <= y0;
            found_ff <= 1'b0;
         end
         B_MARCH: begin
            rx_ff    <= nrx;
            ry_ff    <= nry;
            found_ff <= wall;
         end
         B_SQX: sum_ff <= SQ_W'(sq);
         B_SQY: begin
            v_ff   <= sum_ff + SQ_W'(sq);
            r_ff   <= '0;
            bit_ff <= SQ_W'(1) << 36;
         end
         B_ROOT: begin
            if ((SQ_W+1)'(v_ff) >= root_trial) begin
               v_ff <= v_ff - root_trial[SQ_W-1:0];
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         B_PREP: begin
            d_ff   <= r_ff[ROOT_W-1:0];
            num_ff <= NUM_INIT;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         B_DIV: begin
            rem_ff <= div_ge ? ROOT_W'(div_trial - {1'b0, d_ff}) : div_trial[ROOT_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], div_ge};
            num_ff <= num_ff << 1;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         column_out_ff <= ray_ff.column;
         top_ff        <= top_val[5:0];
         bottom_ff     <= bot_val[5:0];
         shade_ff      <= shade;
         full_ff       <= full;
         dist_ff       <= (d_ff[ROOT_W-1:DIST_W] != '0) ? '1 : d_ff[DIST_W-1:0];
         hit_x_ff      <= rx_ff[RAY_W-1] ? '0 : (rx_ff[28] ? '1 : rx_ff[27:12]);
         hit_y_ff      <= ry_ff[RAY_W-1] ? '0 : (ry_ff[28] ? '1 : ry_ff[27:12]);
         found_out_ff  <= found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_out  = column_out_ff;
   assign rsp_wall_top    = top_ff;
   assign rsp_wall_bottom = bottom_ff;
   assign rsp_shade       = shade_ff;
   assign rsp_full_column = full_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_hit_x       = hit_x_ff;
   assign rsp_hit_y       = hit_y_ff;
   assign rsp_wall_found  = found_out_ff;

endmodule

>>> hw/rtl/raymarch_column_renderer.sv
// channel  | ports                          | moves
// req      | req_valid/ready, req_column    | one column to cast
// rsp      | rsp_valid/ready, rsp_*         | span, shade, distance, hit point
// csr      | csr_valid/ready, csr_index/data| one register write, always ready
//
// an item marches up to MAX_STEPS steps when no wall is hit, fewer otherwise:
// 12 sine steps in the front, one march step per cycle in the back,
// then 19 root digits and one divide bit per cycle.
// the front takes the next column while the back marches; a 2-entry queue sits between.
// a result waits in the output register under rsp stall while the back starts the next ray.
// synchronous active-high reset clears control state and loads register defaults.
//
// top level of the column ray caster; depends on rmcr_pkg, rmcr_front,
// rmcr_queue and rmcr_back

module raymarch_column_renderer import rmcr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int MAX_STEPS     = DEF_MAX_STEPS,
   parameter int MAP_SIZE      = DEF_MAP_SIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COLUMN_W-1:0]  req_column,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COLUMN_W-1:0]  rsp_column_out,
   output logic [5:0]           rsp_wall_top,
   output logic [5:0]           rsp_wall_bottom,
   output logic [2:0]           rsp_shade,
   output logic                 rsp_full_column,
   output logic [DIST_W-1:0]    rsp_distance,
   output logic [POS_W-1:0]     rsp_hit_x,
   output logic [POS_W-1:0]     rsp_hit_y,
   output logic                 rsp_wall_found,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MAP_W-1:0]     csr_data
);

   logic [POS_W-1:0] player_x_ff, player_y_ff, view_angle_ff;
   logic [MAP_W-1:0] map_ff [4];

   logic           q_push, q_pop;
   rmcr_ray_type   push_ray, head_ray;
   rmcr_qstat_type q_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff   <= 16'd56033;
         player_y_ff   <= 16'd9298;
         view_angle_ff <= 16'd57521;
         for (int i = 0; i < 4; i++) map_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PLAYER_X: player_x_ff   <= csr_data[POS_W-1:0];
            CSR_PLAYER_Y: player_y_ff   <= csr_data[POS_W-1:0];
            CSR_VIEW:     view_angle_ff <= csr_data[POS_W-1:0];
            CSR_MAP_0:    map_ff[0]     <= csr_data;
            CSR_MAP_1:    map_ff[1]     <= csr_data;
            CSR_MAP_2:    map_ff[2]     <= csr_data;
            CSR_MAP_3:    map_ff[3]     <= csr_data;
            default: ;
         endcase
      end
   end

   // angle and step vector
   rmcr_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_column (req_column),
      .view_angle (view_angle_ff),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_ray      (push_ray)
   );

   // decoupling queue
   rmcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_ray (push_ray),
      .pop      (q_pop),
      .head_ray (head_ray),
      .stat     (q_stat)
   );

   // march, measure and classify
   rmcr_back #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_STEPS     (MAX_STEPS),
      .MAP_SIZE      (MAP_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_ray           (head_ray),
      .q_pop           (q_pop),
      .player_x        (player_x_ff),
      .player_y        (player_y_ff),
      .map_bits        ({map_ff[3], map_ff[2], map_ff[1], map_ff[0]}),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_column_out  (rsp_column_out),
      .rsp_wall_top    (rsp_wall_top),
      .rsp_wall_bottom (rsp_wall_bottom),
      .rsp_shade       (rsp_shade),
      .rsp_full_column (rsp_full_column),
      .rsp_distance    (rsp_distance),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_wall_found  (rsp_wall_found)
   );

endmodule

>>> hw/rtl/rmcr_checker.sv
// rmcr_checker: port-level checks of the column ray caster result channel
// depends on rmcr_pkg; bound to raymarch_column_renderer

module rmcr_checker import rmcr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COLUMN_W-1:0] rsp_column_out,
   input logic [5:0]          rsp_wall_top,
   input logic [5:0]          rsp_wall_bottom,
   input logic [2:0]          rsp_shade,
   input logic                rsp_full_column,
   input logic [DIST_W-1:0]   rsp_distance
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_out)
                                 && $stable(rsp_distance))
      else $error("result changed under stall");

   // full column means a full-shade span from the top
   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_column |-> rsp_wall_top == 6'd0 && rsp_shade == SHADE_FULL)
      else $error("full column with wrong span or shade");

   // shade code stays within its set
   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shade <= SHADE_LIGHT)
      else $error("shade code out of range");

   // span is ordered
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wall_top <= rsp_wall_bottom)
      else $error("wall top below wall bottom");

endmodule

bind raymarch_column_renderer rmcr_checker u_rmcr_checker (.*);

>>> dv/tb_top.sv
// self-checking testbench for the column ray caster: directed table, then random phases
// depends on rmcr_pkg and raymarch_column_renderer; prediction is done locally
`timescale 1ns / 1ps

module tb_top import rmcr_pkg::*;;

   localparam int  SCREEN_W    = 120;
   localparam int  SCREEN_H    = 40;
   localparam int  STEP_LIMIT  = 1000;
   localparam int  CELLS       = 16;
   localparam int  ITEM_CYCLES = 1100;
   localparam int  CYCLE_LIMIT = 4_000_000;
   localparam int  PHASES      = 8;
   localparam int  PHASE_ITEMS = 70;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0] ALL_WALLS = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [5:0]          wall_top;
      logic [5:0]          wall_bottom;
      logic [2:0]          shade;
      logic                full_column;
      logic [DIST_W-1:0]   distance;
      logic [POS_W-1:0]    hit_x;
      logic [POS_W-1:0]    hit_y;
      logic                wall_found;
   } column_result_type;

   typedef enum logic {ROW_CAST, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [MAP_W-1:0]    data;
      logic [COLUMN_W-1:0] column;
      logic                full_known;   // a full column is obvious from the setup
   } plan_row_type;

   localparam int PLAN_ROWS = 36;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COLUMN_W-1:0]  req_column = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COLUMN_W-1:0]  rsp_column_out;
   logic [5:0]           rsp_wall_top;
   logic [5:0]           rsp_wall_bottom;
   logic [2:0]           rsp_shade;
   logic                 rsp_full_column;
   logic [DIST_W-1:0]    rsp_distance;
   logic [POS_W-1:0]     rsp_hit_x;
   logic [POS_W-1:0]     rsp_hit_y;
   logic                 rsp_wall_found;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAP_W-1:0]     csr_data = '0;

   // local copy of the registers
   logic [15:0]    pos_x, pos_y, view;
   logic [63:0]    map_q [4];

   column_result_type pending_columns [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             casts_directed = 0, casts_random = 0, writes_done = 0, results_seen = 0;
   int             walls_missed = 0, full_seen = 0;

   plan_row_type   plan [PLAN_ROWS];

   raymarch_column_renderer u_dut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic longint unsigned quarter_sine(longint unsigned t);
      longint unsigned t2, a, b, s;
      t2 = (t * t) >> 15;
      a  = 21167 - ((2611 * t2) >> 15);
      b  = 51472 - ((a * t2) >> 15);
      s  = (b * t) >> 15;
      return (s > 32768) ? 32768 : s;
   endfunction

   function automatic longint sine_q15(int unsigned ang);
      logic [15:0]     a;
      longint unsigned t, s;
      a = ang[15:0];
      t = longint'(a[13:0]) << 1;
      s = a[14] ? quarter_sine(32768 - t) : quarter_sine(t);
      return a[15] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint step_size(longint c);
      longint m, s;
      m = (c < 0) ? -c : c;
      s = (419430 * m) >>> 15;
      return (c < 0) ? -s : s;
   endfunction

   function automatic bit cell_blocked(longint rx, longint ry);
      longint cx, cy;
      logic [63:0] row_bits;
      if (rx < 0 || ry < 0) return 1'b1;
      cx = rx >>> 24;
      cy = ry >>> 24;
      if (cx >= CELLS || cy >= CELLS) return 1'b1;
      row_bits = map_q[cy[3:2]];
      return row_bits[cy[1:0] * 16 + cx[3:0]];
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned clamp_pos(longint r);
      longint unsigned v;
      if (r < 0) return 0;
      v = longint'(r) >> 12;
      return (v > 65535) ? 65535 : v;
   endfunction

   function automatic longint unsigned grid_gap(longint r);
      longint unsigned f;
      f = r & 64'h0000_0000_00FF_FFFF;
      return (f < 64'h100_0000 - f) ? f : 64'h100_0000 - f;
   endfunction

   function automatic column_result_type cast_ray(logic [COLUMN_W-1:0] col);
      column_result_type res;
      int unsigned     ang;
      longint          c, s, sx, sy, x0, y0, rx, ry, ddx, ddy;
      longint unsigned ax, ay, d, size, top, bottom;
      logic [2:0]      shade;
      bit              found, full;
      ang = (int'(view) + 65536 - 8192 + (int'(col) * 16384) / SCREEN_W) & 16'hFFFF;
      c   = sine_q15(ang + 16384);
      s   = sine_q15(ang);
      sx  = step_size(c);
      sy  = step_size(s);
      x0  = longint'(pos_x) << 12;
      y0  = longint'(pos_y) << 12;
      rx  = x0;
      ry  = y0;
      found = 1'b0;
      // fixed-step march until a wall cell or the step limit
      for (int n = 0; n < STEP_LIMIT; n++) begin
         rx = rx + sx;
         ry = ry + sy;
         if (cell_blocked(rx, ry)) begin
            found = 1'b1;
            break;
         end
      end
      ddx = rx - x0;
      ddy = ry - y0;
      ax  = ((ddx < 0) ? -ddx : ddx) >> 12;
      ay  = ((ddy < 0) ? -ddy : ddy) >> 12;
      d   = floor_root(ax * ax + ay * ay);
      full  = 1'b0;
      shade = SHADE_BLANK;
      size  = (d == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (((SCREEN_H * 4096) / d) * 5) / 4;
      if (size > FULL_LIMIT) begin
         full   = 1'b1;
         shade  = SHADE_FULL;
         top    = 0;
         bottom = SCREEN_H;
      end else begin
         top    = (size >= SCREEN_H) ? 0 : (SCREEN_H - size) / 2;
         bottom = (SCREEN_H + size) / 2;
         if (bottom > SCREEN_H) bottom = SCREEN_H;
         // corners of the grid stay blank, otherwise banded by distance
         if (grid_gap(rx) > EDGE_Q24 || grid_gap(ry) > EDGE_Q24) begin
            if (d < BAND_1)      shade = SHADE_FULL;
            else if (d < BAND_2) shade = SHADE_DARK;
            else if (d < BAND_3) shade = SHADE_MEDIUM;
            else if (d < BAND_4) shade = SHADE_LIGHT;
         end
      end
      res.column      = col;
      res.wall_top    = top[5:0];
      res.wall_bottom = bottom[5:0];
      res.shade       = shade;
      res.full_column = full;
      res.distance    = (d > 131071) ? 17'h1FFFF : d[16:0];
      res.hit_x       = 16'(clamp_pos(rx));
      res.hit_y       = 16'(clamp_pos(ry));
      res.wall_found  = found;
      return res;
   endfunction

   // ---------------- drivers ----------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 5);
      return $urandom_range(20, 200);
   endfunction

   // one column transfer; valid stays high afterwards until the next call or lower_req
   task automatic cast_column(input logic [COLUMN_W-1:0] col, input int gap,
                              input bit full_known);
      column_result_type want;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_column <= col;
      do @(posedge clock); while (!req_ready);
      want = cast_ray(col);
      if (full_known) begin
         want.full_column = 1'b1;
         want.wall_top    = 6'd0;
         want.wall_bottom = 6'(SCREEN_H);
         want.shade       = SHADE_FULL;
         want.wall_found  = 1'b1;
      end
      pending_columns.push_back(want);
   endtask

   task automatic lower_req();
      @(negedge clock) req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_columns.size() != 0) @(posedge clock);
   endtask

   // register write, only issued with no column in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MAP_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         CSR_PLAYER_X: pos_x = data[15:0];
         CSR_PLAYER_Y: pos_y = data[15:0];
         CSR_VIEW:     view  = data[15:0];
         CSR_MAP_0, CSR_MAP_1, CSR_MAP_2, CSR_MAP_3: map_q[idx - CSR_MAP_0] = data;
         default: ;
      endcase
      writes_done++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] random_map(int mode);
      logic [63:0] a, b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case (mode)
         0: return a & b & {$urandom, $urandom};
         1: return a;
         2: return '0;
         default: return a | b;
      endcase
   endfunction

   function automatic logic [15:0] random_pos();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'($urandom_range(0, 15)) << 12;
      return 16'($urandom);
   endfunction

   // rsp stall pattern: ready bursts, short stalls, a few long ones
   initial begin
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            @(negedge clock) rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 40)) @(negedge clock);
         end else if (r < 97) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat ($urandom_range(20, 300)) @(negedge clock);
         end
      end
   end

   // ---------------- checker ----------------

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      column_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_columns.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result for column %0d", $realtime, rsp_column_out);
         end else begin
            want = pending_columns.pop_front();
            check_field("column_out", want.column, rsp_column_out);
            check_field("wall_top", want.wall_top, rsp_wall_top);
            check_field("wall_bottom", want.wall_bottom, rsp_wall_bottom);
            check_field("shade", want.shade, rsp_shade);
            check_field("full_column", want.full_column, rsp_full_column);
            check_field("distance", want.distance, rsp_distance);
            check_field("hit_x", want.hit_x, rsp_hit_x);
            check_field("hit_y", want.hit_y, rsp_hit_y);
            check_field("wall_found", want.wall_found, rsp_wall_found);
            if (!rsp_wall_found) walls_missed++;
            if (rsp_full_column) full_seen++;
         end
      end
   end

   // ---------------- stimulus ----------------

   initial begin
      int gap_mode;
      pos_x = 16'd56033;
      pos_y = 16'd9298;
      view  = 16'd57521;
      for (int i = 0; i < 4; i++) map_q[i] = '0;

      plan = '{
         // register defaults, screen edges and columns past the screen
         '{ROW_CAST,  '0, '0, 7'd0,   1'b0},
         '{ROW_CAST,  '0, '0, 7'd119, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd60,  1'b0},
         '{ROW_CAST,  '0, '0, 7'd120, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd127, 1'b0},
         // solid map: first step lands in a wall, column is full
         '{ROW_WRITE, CSR_MAP_0, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_1, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_2, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_3, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_X, 64'h8000, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_Y, 64'h8000, '0, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd0,   1'b1},
         '{ROW_CAST,  '0, '0, 7'd119, 1'b1},
         // empty map, player at the origin looking along +x: column 0 leaves the map at once
         '{ROW_WRITE, CSR_MAP_0, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_1, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_2, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_MAP_3, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_X, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_Y, 64'h0, '0, 1'b0},
         '{ROW_WRITE, CSR_VIEW, 64'h0, '0, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd0,   1'b1},
         '{ROW_CAST,  '0, '0, 7'd64,  1'b0},
         '{ROW_CAST,  '0, '0, 7'd127, 1'b0},
         // top corner of the position and angle range
         '{ROW_WRITE, CSR_PLAYER_X, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_Y, ALL_WALLS, '0, 1'b0},
         '{ROW_WRITE, CSR_VIEW, ALL_WALLS, '0, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd0,   1'b0},
         '{ROW_CAST,  '0, '0, 7'd119, 1'b0},
         // unmapped index has no effect
         '{ROW_WRITE, CSR_UNUSED, ALL_WALLS, '0, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd10,  1'b0},
         // integer position on a diagonal toward a single wall cell, near a grid corner
         '{ROW_WRITE, CSR_MAP_0, 64'h0008_0000_0000_0000, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_X, 64'h1000, '0, 1'b0},
         '{ROW_WRITE, CSR_PLAYER_Y, 64'h1000, '0, 1'b0},
         '{ROW_WRITE, CSR_VIEW, 64'h2000, '0, 1'b0},
         '{ROW_CAST,  '0, '0, 7'd0,   1'b0},
         '{ROW_CAST,  '0, '0, 7'd60,  1'b0}
      };

      // reset
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            lower_req();
            write_reg(plan[i].index, plan[i].data);
         end else begin
            cast_column(plan[i].column, pick_gap(), plan[i].full_known);
            casts_directed++;
         end
      end

      // random phases, each with a fresh scene
      for (int p = 0; p < PHASES; p++) begin
         lower_req();
         for (int k = 0; k < 4; k++)
            write_reg(CSR_IDX_W'(CSR_MAP_0 + k),
                      random_map((p == 0) ? 2 : $urandom_range(0, 3)));
         write_reg(CSR_PLAYER_X, {$urandom, 16'h0, random_pos()});
         write_reg(CSR_PLAYER_Y, {$urandom, 16'h0, random_pos()});
         write_reg(CSR_VIEW, {$urandom, $urandom});
         if (p == 3) write_reg(CSR_UNUSED, {$urandom, $urandom});
         gap_mode = p % 3;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once until the block has fully drained
            if (n == PHASE_ITEMS / 2 && p == 1) begin
               lower_req();
               drain_results();
            end
            cast_column(($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 119)),
                        (gap_mode == 0) ? 0 : pick_gap(), 1'b0);
            casts_random++;
         end
      end

      lower_req();
      drain_results();
      repeat (ITEM_CYCLES) @(posedge clock);
      if (pending_columns.size() != 0) error_count += pending_columns.size();

      $display("covered %0d directed and %0d random columns, %0d register writes",
               casts_directed, casts_random, writes_done);
      $display("%0d results checked, %0d full columns, %0d rays without a wall",
               results_seen, full_seen, walls_missed);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
